// ----- rtl/stm_pkg.sv -----
`timescale 1ns / 1ps

package stm_pkg;

  // Datapath sizing
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int TABLE_SIZE      = 1 << SINE_TABLE_BITS;
  localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
  localparam int FRAC_BITS       = PHASE_BITS - SINE_TABLE_BITS;
  localparam int FRAC_SHR        = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
  localparam int FRAC_SHL        = (FRAC_BITS > 16) ? 0 : (16 - FRAC_BITS);
  localparam int NUM_CELLS       = 7;

  localparam longint Q30_ONE = 64'sd1073741824;

  // Output limits, symmetric
  localparam logic signed [20:0] SAT_POS = 21'sd32767;
  localparam logic signed [20:0] SAT_NEG = -21'sd32767;

  // Taylor coefficients of sin(pi/2 * u), Q30, odd powers 1..13
  localparam longint POLY_COEF [7] = '{
    64'sd1686629713, 64'sd693598668, 64'sd85569306, 64'sd5026995,
    64'sd172272, 64'sd3864, 64'sd61
  };

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_PHASE_STEP = 1'b0,
    REG_AMPLITUDE  = 1'b1
  } reg_index_t;

  // Payload carried along the cell chain; fields are reused stage to stage
  typedef struct packed {
    logic signed [15:0] existing;
    logic [15:0]        frac;
    logic signed [31:0] base;
    logic signed [63:0] acc;
  } data_t;

  typedef struct packed {
    logic  valid;
    data_t data;
  } beat_t;

  typedef logic signed [31:0] sine_table_t [TABLE_SIZE];

  // sin(pi/2 * u), u in Q30 over [0, 1]; result Q30
  function automatic longint quarter_sine(longint u);
    longint s;
    longint p;
    int     n;
    s = (u * u) / Q30_ONE;
    p = POLY_COEF[6];
    for (n = 5; n >= 0; n--) begin
      p = POLY_COEF[n] - (p * s) / Q30_ONE;
    end
    p = (p * u) / Q30_ONE;
    if (p > Q30_ONE) p = Q30_ONE;
    if (p < 0) p = 0;
    return p;
  endfunction

  // One full-turn table entry, Q30
  function automatic longint table_entry(int k);
    int     quad;
    int     q;
    longint u;
    longint v;
    quad = (k >> QUARTER_BITS) & 3;
    q    = k & ((1 << QUARTER_BITS) - 1);
    u    = longint'(q) << (30 - QUARTER_BITS);
    if (quad == 0 || quad == 2) v = quarter_sine(u);
    else v = quarter_sine(Q30_ONE - u);
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    int          k;
    for (k = 0; k < TABLE_SIZE; k++) begin
      t[k] = 32'(table_entry(k));
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ----- rtl/stm_cell.sv -----
`timescale 1ns / 1ps

// One elastic register cell of the chain: holds a request until the next cell takes it
module stm_cell
  import stm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  beat_t up,
  output logic  up_ready,
  output beat_t dn,
  input  logic  dn_ready
);

  // free when empty or when the neighbour takes the current request
  assign up_ready = !dn.valid || dn_ready;

  // occupancy and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      dn.valid <= 1'b0;
    end else if (up_ready) begin
      dn.valid <= up.valid;
    end
    if (up_ready && up.valid) begin
      dn.data <= up.data;
    end
  end

endmodule

// ----- rtl/stm_sine_rom.sv -----
`timescale 1ns / 1ps

// Sine table, two registered read ports (entry and its wrapped neighbour)
module stm_sine_rom
  import stm_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic [SINE_TABLE_BITS-1:0] idx,
  output logic signed [31:0]         s0,
  output logic signed [31:0]         s1
);

  logic [SINE_TABLE_BITS-1:0] idx_next;

  // last entry pairs with entry zero
  assign idx_next = idx + SINE_TABLE_BITS'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= SINE_TABLE[idx];
      s1 <= SINE_TABLE[idx_next];
    end
  end

endmodule

// ----- rtl/sine_tone_mix_saturate_top.sv -----
`timescale 1ns / 1ps

// Sine tone mixer. Adds a table-driven sine tone, scaled by a signed amplitude,
// to a stream of signed 16-bit samples and saturates the sum to +-32767.
// Input channel: in_valid / in_ready with existing_sample and restart; a request
// with restart set uses phase zero, after which the phase advances by phase_step.
// Output channel: out_valid / out_ready with mixed_sample.
// Configuration: cfg_we / cfg_index / cfg_data, index 0 = phase_step,
// index 1 = amplitude (cfg_data[16:0]); write only while no request is in flight.
// Throughput: one request per clock while out_ready is high. Each request passes
// through the seven-cell chain to out_valid (phase, table read, difference,
// interpolation multiply, rounding, amplitude multiply, saturation).
// Reset clears the phase, both registers and every cell; no clearing pass.
// When the receiver stalls, the cells hold their requests and bubbles are
// squeezed out; in_ready drops only once all seven cells are occupied.
module sine_tone_mix_saturate_top
  import stm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] existing_sample,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mixed_sample,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0]           phase_step;
  logic signed [16:0]    amplitude;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] step_ext;
  logic [PHASE_BITS+15:0] frac_wide;
  logic [15:0]           frac16;

  beat_t beat_d [NUM_CELLS];
  beat_t beat_q [NUM_CELLS];
  logic  rdy    [NUM_CELLS+1];

  logic signed [31:0] rom_s0;
  logic signed [31:0] rom_s1;
  logic               rom_en;

  logic signed [49:0] interp_prod;
  logic signed [63:0] interp_q;
  logic signed [48:0] tone_prod;
  logic signed [63:0] tone_q;
  logic signed [20:0] mix_sum;
  logic signed [15:0] mix_sat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      amplitude  <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PHASE_STEP: phase_step <= cfg_data;
        REG_AMPLITUDE:  amplitude  <= $signed(cfg_data[16:0]);
        default: ;
      endcase
    end
  end

  // phase accumulator, advanced per accepted request
  assign step_ext  = PHASE_BITS'(phase_step);
  assign phase_cur = restart ? '0 : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (in_valid && in_ready) begin
      phase <= phase_cur + step_ext;
    end
  end

  // interpolation fraction as 16 bits, low bits dropped
  assign frac_wide = {16'b0, phase_cur} & (PHASE_BITS+16)'((64'd1 << FRAC_BITS) - 64'd1);
  assign frac16    = 16'((frac_wide << FRAC_SHL) >> FRAC_SHR);

  // cell chain
  assign rdy[NUM_CELLS] = out_ready;
  assign in_ready       = rdy[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    stm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up       (beat_d[k]),
      .up_ready (rdy[k]),
      .dn       (beat_q[k]),
      .dn_ready (rdy[k+1])
    );
  end

  // table read travels alongside cell one
  assign rom_en = beat_q[0].valid && rdy[1];

  stm_sine_rom u_rom (
    .clk (clk),
    .en  (rom_en),
    .idx (beat_q[0].data.base[SINE_TABLE_BITS-1:0]),
    .s0  (rom_s0),
    .s1  (rom_s1)
  );

  // per-stage work between cells
  always_comb begin
    // cell 0: phase split into table index and fraction
    beat_d[0].valid         = in_valid;
    beat_d[0].data.existing = existing_sample;
    beat_d[0].data.frac     = frac16;
    beat_d[0].data.base     = 32'(phase_cur[PHASE_BITS-1 -: SINE_TABLE_BITS]);
    beat_d[0].data.acc      = '0;

    // cell 1: table read in flight
    beat_d[1] = beat_q[0];

    // cell 2: base entry and slope to the neighbour
    beat_d[2]           = beat_q[1];
    beat_d[2].data.base = rom_s0;
    beat_d[2].data.acc  = 64'(rom_s1) - 64'(rom_s0);

    // cell 3: slope times fraction
    interp_prod        = $signed(beat_q[2].data.acc[32:0]) * $signed({1'b0, beat_q[2].data.frac});
    beat_d[3]          = beat_q[2];
    beat_d[3].data.acc = 64'(interp_prod);

    // cell 4: divide by 2^16 toward zero, add base
    interp_q = beat_q[3].data.acc >>> 16;
    if (beat_q[3].data.acc < 0 && (|beat_q[3].data.acc[15:0])) begin
      interp_q = interp_q + 64'sd1;
    end
    beat_d[4]           = beat_q[3];
    beat_d[4].data.base = beat_q[3].data.base + 32'(interp_q);
    beat_d[4].data.acc  = '0;

    // cell 5: scale by amplitude
    tone_prod          = beat_q[4].data.base * amplitude;
    beat_d[5]          = beat_q[4];
    beat_d[5].data.acc = 64'(tone_prod);

    // cell 6: divide by 2^30 toward zero, mix, saturate
    tone_q = beat_q[5].data.acc >>> 30;
    if (beat_q[5].data.acc < 0 && (|beat_q[5].data.acc[29:0])) begin
      tone_q = tone_q + 64'sd1;
    end
    mix_sum = 21'(tone_q) + 21'(beat_q[5].data.existing);
    if (mix_sum > SAT_POS) begin
      mix_sat = 16'(SAT_POS);
    end else if (mix_sum < SAT_NEG) begin
      mix_sat = 16'(SAT_NEG);
    end else begin
      mix_sat = 16'(mix_sum);
    end
    beat_d[6]          = beat_q[5];
    beat_d[6].data.acc = 64'(mix_sat);
  end

  assign out_valid    = beat_q[NUM_CELLS-1].valid;
  assign mixed_sample = beat_q[NUM_CELLS-1].data.acc[15:0];

  // checks
  a_no_neg_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mixed_sample != 16'sh8000)
    else $error("mixed_sample reached the negative full-scale code");

  a_restart_phase: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && restart) |=> phase == $past(step_ext))
    else $error("phase after restart is not one step from zero");

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("chain refused a request while the output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule
